>>> design/oetr_pkg.sv
// Shared types and constants of the overwriting event trace ring.
`default_nettype none
package oetr_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int SLOT_MAX_W  = 6;
  localparam int CNT_MAX_W   = 7;

  localparam logic STATUS_REFUSED = 1'b1;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RD_LIST    = 2'd0,
    RD_EMPTY   = 2'd1,
    RD_REFUSED = 2'd2
  } read_class_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] cycle;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } event_t;

  typedef struct packed {
    op_t                   op;
    logic [SLOT_MAX_W-1:0] slot;
    event_t                ev;
    read_class_t           rclass;
    logic [31:0]           base;
    logic [31:0]           newest;
    logic [31:0]           drops;
    logic [CNT_MAX_W-1:0]  q1;
    logic [CNT_MAX_W-1:0]  q2;
    logic [CNT_MAX_W-1:0]  j1;
    logic [CNT_MAX_W-1:0]  j2;
    logic [CNT_MAX_W-1:0]  cap;
  } ring_cmd_t;

  typedef struct packed {
    logic        status;
    logic        has_entry;
    logic [31:0] serial;
    logic [4:0]  kind;
    logic [31:0] cycle;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] next_cursor;
    logic [31:0] drop_total;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

>>> design/oetr_front.sv
// Front end: ring bookkeeping on appends and classification of read requests.
`default_nettype none
module oetr_front import oetr_pkg::*; #(
  parameter int RING_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  op_t         in_op,
  input  event_t      in_event,
  input  logic [31:0] in_cursor,
  input  logic [5:0]  in_cap,
  input  logic        q_full,
  output logic        q_push,
  output ring_cmd_t   q_cmd
);

  localparam int SW      = $clog2(RING_DEPTH);
  localparam int CW      = $clog2(RING_DEPTH + 1);
  localparam int CAP_LIM = (RING_DEPTH < MAX_RESULTS) ? RING_DEPTH : MAX_RESULTS;

  logic [SW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [31:0]   newest_r, newest_nxt;
  logic [31:0]   oldest_r, oldest_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [31:0]   drops_r, drops_nxt;

  logic          full;
  logic [31:0]   oldest_tmp;
  logic          wrap;
  logic [31:0]   e1;
  logic [CW-1:0] l1, q1, q2, j1, j2;
  logic [5:0]    cap_eff;
  logic [SW:0]   fs_sum;
  logic [SW-1:0] first_slot;
  read_class_t   rclass;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign full     = (fill_r == CW'(RING_DEPTH));

  always_comb begin
    newest_nxt = newest_r + 32'd1;
    if (full) begin
      drops_nxt  = drops_r + 32'd1;
      base_nxt   = base_r + 32'd1;
      fill_nxt   = fill_r;
      oldest_tmp = newest_r - 32'(RING_DEPTH) + 32'd2;
    end else begin
      drops_nxt  = drops_r;
      base_nxt   = base_r;
      fill_nxt   = fill_r + CW'(1);
      oldest_tmp = oldest_r;
    end
    oldest_nxt = (oldest_tmp == 32'd0) ? newest_nxt : oldest_tmp;
    wp_nxt = (wp_r == SW'(RING_DEPTH - 1)) ? '0 : wp_r + SW'(1);
  end

  always_comb begin
    wrap = (newest_r < base_r);
    e1   = wrap ? 32'hFFFF_FFFF : newest_r;
    l1   = wrap ? CW'(32'd0 - base_r) : fill_r;
    if (in_cursor >= e1) begin
      q1 = '0;
    end else if (in_cursor < base_r) begin
      q1 = l1;
    end else begin
      q1 = CW'(e1 - in_cursor);
    end
    q2 = (wrap && (in_cursor < newest_r)) ? CW'(newest_r - in_cursor) : '0;
    j1 = l1 - q1;
    j2 = fill_r - q2;
    cap_eff = (in_cap > 6'(CAP_LIM)) ? 6'(CAP_LIM) : in_cap;
    fs_sum = (SW+1)'(wp_r) + (SW+1)'(RING_DEPTH) - (SW+1)'(fill_r);
    first_slot = (fs_sum >= (SW+1)'(RING_DEPTH)) ? SW'(fs_sum - (SW+1)'(RING_DEPTH))
                                                 : SW'(fs_sum);
    priority if (fill_r == '0) begin
      rclass = RD_EMPTY;
    end else if ((in_cursor != 32'd0) && ((in_cursor + 32'd1) < oldest_r)) begin
      rclass = RD_REFUSED;
    end else begin
      rclass = RD_LIST;
    end
  end

  always_comb begin
    q_cmd        = '0;
    q_cmd.op     = in_op;
    q_cmd.slot   = (in_op == OP_APPEND) ? SLOT_MAX_W'(wp_r) : SLOT_MAX_W'(first_slot);
    q_cmd.ev     = in_event;
    q_cmd.rclass = rclass;
    q_cmd.base   = base_r;
    q_cmd.newest = newest_r;
    q_cmd.drops  = drops_r;
    q_cmd.q1     = CNT_MAX_W'(q1);
    q_cmd.q2     = CNT_MAX_W'(q2);
    q_cmd.j1     = CNT_MAX_W'(j1);
    q_cmd.j2     = CNT_MAX_W'(j2);
    q_cmd.cap    = CNT_MAX_W'(cap_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      fill_r   <= '0;
      newest_r <= '0;
      oldest_r <= '0;
      base_r   <= 32'd1;
      drops_r  <= '0;
    end else if (q_push && (in_op == OP_APPEND)) begin
      wp_r     <= wp_nxt;
      fill_r   <= fill_nxt;
      newest_r <= newest_nxt;
      oldest_r <= oldest_nxt;
      base_r   <= base_nxt;
      drops_r  <= drops_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/oetr_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none
module oetr_queue import oetr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ring_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      pop_valid,
  output ring_cmd_t pop_cmd
);

  ring_cmd_t  entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/oetr_back.sv
// Back end: event storage, batch sequencer, read data stage and output register.
`default_nettype none
module oetr_back import oetr_pkg::*; #(
  parameter int RING_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  ring_cmd_t q_cmd,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res
);

  localparam int SW = $clog2(RING_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  state_t               state_r;
  ring_cmd_t            cur_r;
  logic [CNT_MAX_W-1:0] rem_r, rem1_r, idx_r;
  logic [31:0]          next_cur_r;
  logic                 b_valid_r;
  result_t              b_res_r;
  logic                 out_valid_r;
  result_t              out_r;
  event_t               rd_data_r;
  event_t               mem [RING_DEPTH];

  logic                 b_move, b_free;
  logic                 wr_en, rd_en, iss;
  result_t              iss_res, b_out;
  logic [SW:0]          slot_sum;
  logic [SW-1:0]        rd_slot;
  logic [CNT_MAX_W-1:0] sum_q, n, c1, c2, last_idx;
  logic [31:0]          last_serial;

  assign out_valid = out_valid_r;
  assign out_res   = out_r;
  assign b_move    = b_valid_r && (!out_valid_r || out_ready);
  assign b_free    = !b_valid_r || b_move;

  always_comb begin
    slot_sum = (SW+1)'(cur_r.slot) + (SW+1)'(idx_r);
    rd_slot  = (slot_sum >= (SW+1)'(RING_DEPTH)) ? SW'(slot_sum - (SW+1)'(RING_DEPTH))
                                                 : SW'(slot_sum);
    sum_q    = cur_r.q1 + cur_r.q2;
    n        = (cur_r.cap < sum_q) ? cur_r.cap : sum_q;
    c1       = (n < cur_r.q1) ? n : cur_r.q1;
    c2       = n - c1;
    last_idx = (c2 == '0) ? cur_r.j1 + c1 - CNT_MAX_W'(1) : cur_r.j2 + c2 - CNT_MAX_W'(1);
    last_serial = cur_r.base + 32'(last_idx);
  end

  always_comb begin
    q_pop   = 1'b0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    iss     = 1'b0;
    iss_res = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_cmd.op == OP_APPEND) begin
            wr_en = 1'b1;
            q_pop = 1'b1;
          end else begin
            unique case (q_cmd.rclass)
              RD_LIST: begin
                q_pop = 1'b1;
              end
              RD_REFUSED: begin
                if (b_free) begin
                  q_pop               = 1'b1;
                  iss                 = 1'b1;
                  iss_res.status      = STATUS_REFUSED;
                  iss_res.last        = 1'b1;
                  iss_res.next_cursor = q_cmd.newest;
                  iss_res.drop_total  = q_cmd.drops;
                end
              end
              default: begin
                if (b_free) begin
                  q_pop               = 1'b1;
                  iss                 = 1'b1;
                  iss_res.last        = 1'b1;
                  iss_res.next_cursor = q_cmd.newest;
                  iss_res.drop_total  = q_cmd.drops;
                end
              end
            endcase
          end
        end
      end
      ST_SETUP: begin
      end
      ST_RUN: begin
        if (b_free) begin
          iss                 = 1'b1;
          iss_res.next_cursor = next_cur_r;
          iss_res.drop_total  = cur_r.drops;
          if (rem_r == '0) begin
            iss_res.last = 1'b1;
          end else begin
            rd_en             = 1'b1;
            iss_res.has_entry = 1'b1;
            iss_res.serial    = cur_r.base + 32'(idx_r);
            iss_res.last      = (rem_r == CNT_MAX_W'(1));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    b_out = b_res_r;
    if (b_res_r.has_entry) begin
      b_out.kind  = rd_data_r.kind;
      b_out.cycle = rd_data_r.cycle;
      b_out.a     = rd_data_r.a;
      b_out.b     = rd_data_r.b;
      b_out.c     = rd_data_r.c;
      b_out.d     = rd_data_r.d;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_cmd.slot[SW-1:0]] <= q_cmd.ev;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_move) begin
        out_r       <= b_out;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (iss) begin
        b_valid_r <= 1'b1;
        b_res_r   <= iss_res;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop && (q_cmd.op == OP_READ) && (q_cmd.rclass == RD_LIST)) begin
            cur_r   <= q_cmd;
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          rem_r      <= n;
          rem1_r     <= c1;
          idx_r      <= (c1 != '0) ? cur_r.j1 : cur_r.j2;
          next_cur_r <= (n == '0) ? cur_r.newest : last_serial;
          state_r    <= ST_RUN;
        end
        ST_RUN: begin
          if (iss) begin
            if ((rem_r == '0) || (rem_r == CNT_MAX_W'(1))) begin
              state_r <= ST_IDLE;
            end
            if (rem_r != '0) begin
              rem_r <= rem_r - CNT_MAX_W'(1);
            end
            if (rem1_r == CNT_MAX_W'(1)) begin
              idx_r <= cur_r.j2;
            end else begin
              idx_r <= idx_r + CNT_MAX_W'(1);
            end
            if (rem1_r != '0) begin
              rem1_r <= rem1_r - CNT_MAX_W'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/overwriting_event_trace_ring_unit.sv
// Top level of the overwriting event trace ring.
//
// The input stream carries append and read requests; tuser selects the kind.
// An append stores one event under the next serial number and produces no
// transfer on the output stream. When the ring is full the oldest event is
// overwritten and the drop total grows by one. A read produces one output
// transfer per returned event, oldest first, with tlast on the final one,
// or a single transfer without an entry when nothing qualifies or when the
// cursor has fallen behind the surviving events.
// Appends are taken one per cycle while the queue is not full. A read passes the queue,
// setup and run states, read data stage and output register (an empty ring or refused
// cursor skips setup, run and the read), then one result per cycle while the receiver
// is ready; the memory's single read port, walked by the batch sequencer, sets the rate.
// A two-entry command queue separates the request side from the sequencer,
// and an output register holds a result while the receiver stalls; the
// input stream keeps accepting until the queue is full.
// Reset empties the ring, clears the drop total and restarts serials at one.
`default_nettype none
module overwriting_event_trace_ring_unit import oetr_pkg::*; #(
  parameter int RING_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // event_kind, cycle_stamp, arg_a, arg_b, arg_c, arg_d, cursor_serial, batch_cap
  input  logic [207:0] in_tdata,
  // operation
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_serial, entry_kind, entry_cycle, out_a, out_b, out_c, out_d,
  // next_cursor, drop_total
  output logic [263:0] out_tdata,
  // status, has_entry
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  event_t    in_event;
  op_t       in_op;
  ring_cmd_t push_cmd, pop_cmd;
  logic      q_push, q_full, q_pop, q_valid;
  result_t   res;

  assign in_op          = op_t'(in_tuser[0]);
  assign in_event.kind  = in_tdata[4:0];
  assign in_event.cycle = in_tdata[36:5];
  assign in_event.a     = in_tdata[68:37];
  assign in_event.b     = in_tdata[100:69];
  assign in_event.c     = in_tdata[132:101];
  assign in_event.d     = in_tdata[164:133];

  oetr_front #(
    .RING_DEPTH(RING_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_op),
    .in_event (in_event),
    .in_cursor(in_tdata[196:165]),
    .in_cap   (in_tdata[202:197]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  oetr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_cmd  (pop_cmd)
  );

  oetr_back #(
    .RING_DEPTH(RING_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {3'b000, res.drop_total, res.next_cursor, res.d, res.c, res.b, res.a,
                      res.cycle, res.kind, res.serial};
  assign out_tuser = {res.has_entry, res.status};
  assign out_tlast = res.last;

endmodule
`default_nettype wire

>>> tb/sv/trace_ring_checker.sv
// Watches both streams of the trace ring, predicts every read result and compares them.
`timescale 1ns / 100ps
module trace_ring_checker import oetr_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [207:0] in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [263:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         out_tlast,
  output int           mismatch_count,
  output int           results_pending
);

  localparam int DEPTH = 32;

  logic [31:0] slot_serial_m [DEPTH];
  event_t      slot_event_m [DEPTH];
  logic [4:0]  write_slot;
  logic [5:0]  held_count;
  logic [31:0] newest_seen_m;
  logic [31:0] oldest_kept_m;
  logic [31:0] drop_count;
  result_t     batch_q[$];

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    end
  endtask

  task automatic store_event(input event_t ev);
    if (held_count >= DEPTH) begin
      drop_count    = drop_count + 32'd1;
      oldest_kept_m = slot_serial_m[write_slot] + 32'd1;
    end else begin
      held_count = held_count + 6'd1;
    end
    newest_seen_m             = newest_seen_m + 32'd1;
    slot_serial_m[write_slot] = newest_seen_m;
    slot_event_m[write_slot]  = ev;
    if (oldest_kept_m == 32'd0) begin
      oldest_kept_m = newest_seen_m;
    end
    write_slot = write_slot + 5'd1;
  endtask

  task automatic predict_batch(input logic [31:0] cursor, input logic [5:0] cap);
    result_t     no_entry;
    result_t     entry;
    result_t     found[$];
    logic [31:0] next_serial;
    logic [4:0]  first_slot;
    logic [4:0]  s;
    int          limit;
    int          i;

    no_entry             = '0;
    no_entry.next_cursor = newest_seen_m;
    no_entry.drop_total  = drop_count;
    no_entry.last        = 1'b1;
    if (held_count == 0) begin
      batch_q.push_back(no_entry);
      return;
    end
    if (cursor != 32'd0 && cursor + 32'd1 < oldest_kept_m) begin
      no_entry.status = STATUS_REFUSED;
      batch_q.push_back(no_entry);
      return;
    end
    limit       = (cap > DEPTH) ? DEPTH : int'(cap);
    first_slot  = write_slot - held_count[4:0];
    next_serial = newest_seen_m;
    for (i = 0; i < int'(held_count) && found.size() < limit; i++) begin
      s = first_slot + i[4:0];
      if (slot_serial_m[s] > cursor) begin
        entry            = '0;
        entry.has_entry  = 1'b1;
        entry.serial     = slot_serial_m[s];
        entry.kind       = slot_event_m[s].kind;
        entry.cycle      = slot_event_m[s].cycle;
        entry.a          = slot_event_m[s].a;
        entry.b          = slot_event_m[s].b;
        entry.c          = slot_event_m[s].c;
        entry.d          = slot_event_m[s].d;
        entry.drop_total = drop_count;
        next_serial      = slot_serial_m[s];
        found.push_back(entry);
      end
    end
    if (found.size() == 0) begin
      batch_q.push_back(no_entry);
      return;
    end
    for (i = 0; i < found.size(); i++) begin
      entry             = found[i];
      entry.next_cursor = next_serial;
      entry.last        = (i == found.size() - 1);
      batch_q.push_back(entry);
    end
  endtask

  task automatic compare_result();
    result_t want;

    if (batch_q.size() == 0) begin
      report_mismatch("result transfer arrived with no result pending");
      return;
    end
    want = batch_q.pop_front();
    check_field("status", 32'(out_tuser[0]), 32'(want.status));
    check_field("has_entry", 32'(out_tuser[1]), 32'(want.has_entry));
    check_field("entry_serial", out_tdata[31:0], want.serial);
    check_field("entry_kind", 32'(out_tdata[36:32]), 32'(want.kind));
    check_field("entry_cycle", out_tdata[68:37], want.cycle);
    check_field("out_a", out_tdata[100:69], want.a);
    check_field("out_b", out_tdata[132:101], want.b);
    check_field("out_c", out_tdata[164:133], want.c);
    check_field("out_d", out_tdata[196:165], want.d);
    check_field("next_cursor", out_tdata[228:197], want.next_cursor);
    check_field("drop_total", out_tdata[260:229], want.drop_total);
    check_field("last", 32'(out_tlast), 32'(want.last));
  endtask

  always @(posedge clk) begin
    event_t ev;

    if (!rst_n) begin
      write_slot     = '0;
      held_count     = '0;
      newest_seen_m  = '0;
      oldest_kept_m  = '0;
      drop_count     = '0;
      mismatch_count = 0;
      batch_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        compare_result();
      end
      if (in_tvalid && in_tready) begin
        if (op_t'(in_tuser[0]) == OP_APPEND) begin
          ev.kind  = in_tdata[4:0];
          ev.cycle = in_tdata[36:5];
          ev.a     = in_tdata[68:37];
          ev.b     = in_tdata[100:69];
          ev.c     = in_tdata[132:101];
          ev.d     = in_tdata[164:133];
          store_event(ev);
        end else begin
          predict_batch(in_tdata[196:165], in_tdata[202:197]);
        end
      end
    end
    results_pending <= batch_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the trace ring testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps
module testbench;
  import oetr_pkg::*;

  localparam int RANDOM_ITEMS = 405;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [207:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [263:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;
  int           mismatch_count;
  int           results_pending;

  bit           calm_tail = 1'b0;
  bit           hold_request = 1'b0;
  bit           hold_finished = 1'b0;
  logic [31:0]  appended = '0;

  overwriting_event_trace_ring_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  trace_ring_checker checker_inst (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input op_t op, input logic [4:0] kind,
                           input logic [31:0] cyc, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c,
                           input logic [31:0] d, input logic [31:0] cursor,
                           input logic [5:0] cap, input bit allow_gap);
    in_tdata  <= {5'b0, cap, cursor, d, c, b, a, cyc, kind};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_APPEND) begin
      appended = appended + 32'd1;
    end
    if (allow_gap && !calm_tail && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic send_random(input bit force_read, input bit allow_gap);
    op_t         op;
    logic [4:0]  kind;
    logic [31:0] cursor;
    logic [5:0]  cap;

    op = (force_read || $urandom_range(0, 99) < 45) ? OP_READ : OP_APPEND;
    kind = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'($urandom_range(1, 17));
    case ($urandom_range(0, 19))
      0, 1, 2: cursor = 32'd0;
      3:       cursor = $urandom;
      4:       cursor = 32'hFFFF_FFFF;
      5:       cursor = appended;
      default: cursor = appended - 32'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 19))
      0:       cap = 6'd0;
      1, 2:    cap = 6'($urandom_range(33, 63));
      3, 4, 5: cap = 6'($urandom_range(1, 4));
      default: cap = 6'($urandom_range(1, 32));
    endcase
    send_item(op, kind, pick_word(), pick_word(), pick_word(), pick_word(),
              pick_word(), cursor, cap, allow_gap);
  endtask

  initial begin
    int held_cycles;
    int span;

    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request && !hold_finished) begin
        out_tready <= 1'b0;
        for (held_cycles = 0; held_cycles < 400; held_cycles++) @(posedge clk);
        hold_finished = 1'b1;
      end else if (!calm_tail && $urandom_range(0, 2) != 0) begin
        for (span = 0; span < 64; span++) begin
          if (!calm_tail && $urandom_range(0, 5) == 0) begin
            out_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
          end
          out_tready <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_tready <= 1'b1;
        repeat (64) @(posedge clk);
      end
    end
  end

  initial begin
    int n;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_READ, 5'd3, '0, '0, '0, '0, '0, 32'd0, 6'd4, 1'b0);
    send_item(OP_READ, 5'd3, '0, '0, '0, '0, '0, 32'd0, 6'd0, 1'b0);
    send_item(OP_APPEND, 5'd0, '0, '0, '0, '0, '0, 32'd0, 6'd0, 1'b0);
    send_item(OP_APPEND, 5'd17, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 6'd63, 1'b0);
    send_item(OP_APPEND, 5'd31, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h8000_0000, 32'h8000_0000, 32'd0, 6'd1, 1'b0);
    send_item(OP_APPEND, 5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 6'd2, 1'b0);
    send_item(OP_APPEND, 5'd16, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
              32'hAAAA_AAAA, 32'h5555_5555, 32'd9, 6'd31, 1'b0);
    send_item(OP_APPEND, 5'd10, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, 6'($urandom), 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, 32'd0, 6'd1, 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, 32'd0, 6'd0, 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, 32'd0, 6'd63, 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, 32'd2, 6'd2, 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, appended, 6'd32, 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF, 6'd32, 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, 32'h8000_0000, 6'd5, 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, 32'd1, 6'd32, 1'b0);
    send_item(OP_READ, 5'd0, '0, '0, '0, '0, '0, 32'd0, 6'd33, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 150) begin
        hold_request = 1'b1;
      end
      if (n == RANDOM_ITEMS - 60) begin
        calm_tail = 1'b1;
      end
      send_random(n >= 150 && n < 180, (n / 40) % 3 != 2);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
